@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C command-then-read master: shared definitions
// Word layouts, phase, action and status codes used by all sequencer files.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // Width of the read length latch and the byte counter.
   localparam int LEN_W = 8;

   // Controller status codes after masking with the status mask.
   localparam logic [7:0] STATUS_MASK    = 8'hF8;
   localparam logic [7:0] TWS_START      = 8'h08;
   localparam logic [7:0] TWS_REP_START  = 8'h10;
   localparam logic [7:0] TWS_SLAW_ACK   = 8'h18;
   localparam logic [7:0] TWS_DATAW_ACK  = 8'h28;
   localparam logic [7:0] TWS_SLAR_ACK   = 8'h40;
   localparam logic [7:0] TWS_BUS_ERROR  = 8'h00;

   typedef enum logic {
      OP_REQUEST = 1'b0,
      OP_EVENT   = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_CMD_START = 3'd1,
      PH_CMD_ADDR  = 3'd2,
      PH_CMD_DATA  = 3'd3,
      PH_RD_START  = 3'd4,
      PH_RD_ADDR   = 3'd5,
      PH_RD_DATA   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_START     = 3'd1,
      ACT_SEND      = 3'd2,
      ACT_READ_ACK  = 3'd3,
      ACT_READ_NACK = 3'd4,
      ACT_STOP      = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_UNKNOWN = 3'd1,
      ST_UNAVAIL = 3'd2,
      ST_NACKED  = 3'd3,
      ST_BUSY    = 3'd4
   } status_type;

   typedef struct packed {
      logic       opcode;
      logic [6:0] slave_address;
      logic [7:0] command_byte;
      logic [7:0] read_length;
      logic [7:0] bus_status;
      logic [7:0] bus_data;
   } req_word_type;

   typedef struct packed {
      logic [2:0] bus_action;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       done_res;
      logic [2:0] status;
   } rsp_word_type;

   // Handshake control passed from the top level to the pipeline stages.
   typedef struct packed {
      logic adv;      // input register moves into the result register
      logic out_free; // result register can be loaded this cycle
   } pipe_ctl_type;

endpackage

@@ rtl/i2cm_if.sv @@
// ----------------------------------------------------------------------------
// I2C command-then-read master: channel interfaces
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [6:0] slave_address;
   logic [7:0] command_byte;
   logic [7:0] read_length;
   logic [7:0] bus_status;
   logic [7:0] bus_data;

   modport source (
      output valid, opcode, slave_address, command_byte, read_length,
             bus_status, bus_data,
      input  ready
   );
   modport sink (
      input  valid, opcode, slave_address, command_byte, read_length,
             bus_status, bus_data,
      output ready
   );
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] bus_action;
   logic [7:0] tx_byte;
   logic       rx_valid;
   logic [7:0] rx_byte;
   logic       done_res;
   logic [2:0] status;

   modport source (
      output valid, bus_action, tx_byte, rx_valid, rx_byte, done_res, status,
      input  ready
   );
   modport sink (
      input  valid, bus_action, tx_byte, rx_valid, rx_byte, done_res, status,
      output ready
   );
endinterface

@@ rtl/i2cm_ireg.sv @@
// ----------------------------------------------------------------------------
// I2C command-then-read master: input register
// Captures one request word and holds it until the sequencer consumes it.
// ----------------------------------------------------------------------------
module i2cm_ireg (
   input  logic                  clock,
   input  logic                  reset,
   i2cm_req_if.sink              req_chan,
   input  i2cm_pkg::pipe_ctl_type ctl,
   output logic                  in_vld,
   output i2cm_pkg::req_word_type in_word
);
   import i2cm_pkg::*;

   logic         vld_ff;
   logic         vld_in;
   req_word_type word_ff;
   logic         take;

   // Free when empty, or when the held word leaves in this cycle.
   assign req_chan.ready = !vld_ff || ctl.adv;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (ctl.adv) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff.opcode        <= req_chan.opcode;
         word_ff.slave_address <= req_chan.slave_address;
         word_ff.command_byte  <= req_chan.command_byte;
         word_ff.read_length   <= req_chan.read_length;
         word_ff.bus_status    <= req_chan.bus_status;
         word_ff.bus_data      <= req_chan.bus_data;
      end
   end

   assign in_vld  = vld_ff;
   assign in_word = word_ff;

endmodule

@@ rtl/i2cm_core.sv @@
// ----------------------------------------------------------------------------
// I2C command-then-read master: transaction sequencer
// Holds the transaction state and decides the next bus action for a word.
// ----------------------------------------------------------------------------
module i2cm_core (
   input  logic                   clock,
   input  logic                   reset,
   input  i2cm_pkg::pipe_ctl_type ctl,
   input  i2cm_pkg::req_word_type in_word,
   output i2cm_pkg::rsp_word_type res
);
   import i2cm_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [6:0]       target_address_ff, target_address_in;
   logic [7:0]       command_latch_ff, command_latch_in;
   logic [LEN_W-1:0] length_latch_ff, length_latch_in;
   logic [LEN_W-1:0] bytes_read_ff, bytes_read_in;
   logic [7:0]       st;
   logic [LEN_W-1:0] cnt_next;
   logic [LEN_W-1:0] cnt_after;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         target_address_ff <= '0;
         command_latch_ff  <= '0;
         length_latch_ff   <= '0;
         bytes_read_ff     <= '0;
      end else if (ctl.adv) begin
         phase_ff          <= phase_in;
         target_address_ff <= target_address_in;
         command_latch_ff  <= command_latch_in;
         length_latch_ff   <= length_latch_in;
         bytes_read_ff     <= bytes_read_in;
      end
   end

   assign st        = in_word.bus_status & STATUS_MASK;
   assign cnt_next  = bytes_read_ff + LEN_W'(1);
   assign cnt_after = cnt_next + LEN_W'(1);

   always_comb begin
      phase_in          = phase_ff;
      target_address_in = target_address_ff;
      command_latch_in  = command_latch_ff;
      length_latch_in   = length_latch_ff;
      bytes_read_in     = bytes_read_ff;
      res               = '0;

      if (in_word.opcode == OP_REQUEST) begin
         if (phase_ff != PH_IDLE) begin
            res.done_res = 1'b1;
            res.status   = ST_BUSY;
         end else begin
            target_address_in = in_word.slave_address;
            command_latch_in  = in_word.command_byte;
            length_latch_in   = LEN_W'(in_word.read_length);
            bytes_read_in     = '0;
            phase_in          = PH_CMD_START;
            res.bus_action    = ACT_START;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               res = '0;
            end
            PH_CMD_START: begin
               if (st != TWS_START) begin
                  // A failed first START leaves the bus alone: no STOP.
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = ST_UNKNOWN;
               end else begin
                  phase_in       = PH_CMD_ADDR;
                  res.bus_action = ACT_SEND;
                  res.tx_byte    = {target_address_ff, 1'b0};
               end
            end
            PH_CMD_ADDR: begin
               if (st != TWS_SLAW_ACK) begin
                  phase_in       = PH_IDLE;
                  res.bus_action = ACT_STOP;
                  res.done_res   = 1'b1;
                  res.status     = ST_UNAVAIL;
               end else begin
                  phase_in       = PH_CMD_DATA;
                  res.bus_action = ACT_SEND;
                  res.tx_byte    = command_latch_ff;
               end
            end
            PH_CMD_DATA: begin
               if (st != TWS_DATAW_ACK) begin
                  phase_in       = PH_IDLE;
                  res.bus_action = ACT_STOP;
                  res.done_res   = 1'b1;
                  res.status     = ST_NACKED;
               end else if (length_latch_ff == '0) begin
                  phase_in       = PH_IDLE;
                  res.bus_action = ACT_STOP;
                  res.done_res   = 1'b1;
                  res.status     = ST_OK;
               end else begin
                  phase_in       = PH_RD_START;
                  res.bus_action = ACT_START;
               end
            end
            PH_RD_START: begin
               if (st != TWS_REP_START) begin
                  phase_in       = PH_IDLE;
                  res.bus_action = ACT_STOP;
                  res.done_res   = 1'b1;
                  res.status     = ST_UNKNOWN;
               end else begin
                  phase_in       = PH_RD_ADDR;
                  res.bus_action = ACT_SEND;
                  res.tx_byte    = {target_address_ff, 1'b1};
               end
            end
            PH_RD_ADDR: begin
               if (st != TWS_SLAR_ACK) begin
                  phase_in       = PH_IDLE;
                  res.bus_action = ACT_STOP;
                  res.done_res   = 1'b1;
                  res.status     = ST_UNAVAIL;
               end else begin
                  phase_in       = PH_RD_DATA;
                  res.bus_action = (length_latch_ff == LEN_W'(1)) ? ACT_READ_NACK
                                                                  : ACT_READ_ACK;
               end
            end
            PH_RD_DATA: begin
               if (st == TWS_BUS_ERROR) begin
                  phase_in       = PH_IDLE;
                  res.bus_action = ACT_STOP;
                  res.done_res   = 1'b1;
                  res.status     = ST_UNKNOWN;
               end else begin
                  bytes_read_in = cnt_next;
                  res.rx_valid  = 1'b1;
                  res.rx_byte   = in_word.bus_data;
                  if (cnt_next == length_latch_ff) begin
                     phase_in       = PH_IDLE;
                     res.bus_action = ACT_STOP;
                     res.done_res   = 1'b1;
                     res.status     = ST_OK;
                  end else if (cnt_after == length_latch_ff) begin
                     res.bus_action = ACT_READ_NACK;
                  end else begin
                     res.bus_action = ACT_READ_ACK;
                  end
               end
            end
            default: begin
               // Unused phase code: drop the transaction and report it.
               phase_in     = PH_IDLE;
               res.done_res = 1'b1;
               res.status   = ST_UNKNOWN;
            end
         endcase
      end
   end

endmodule

@@ rtl/i2cm_oreg.sv @@
// ----------------------------------------------------------------------------
// I2C command-then-read master: result register
// Holds one response word until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cm_oreg (
   input  logic                   clock,
   input  logic                   reset,
   input  i2cm_pkg::pipe_ctl_type ctl,
   input  i2cm_pkg::rsp_word_type res,
   i2cm_rsp_if.source             rsp_chan,
   output logic                   out_free
);
   import i2cm_pkg::*;

   logic         vld_ff;
   logic         vld_in;
   rsp_word_type word_ff;

   assign out_free = !vld_ff || rsp_chan.ready;

   always_comb begin
      vld_in = vld_ff;
      if (ctl.adv) begin
         vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         word_ff <= res;
      end
   end

   assign rsp_chan.valid      = vld_ff;
   assign rsp_chan.bus_action = word_ff.bus_action;
   assign rsp_chan.tx_byte    = word_ff.tx_byte;
   assign rsp_chan.rx_valid   = word_ff.rx_valid;
   assign rsp_chan.rx_byte    = word_ff.rx_byte;
   assign rsp_chan.done_res   = word_ff.done_res;
   assign rsp_chan.status     = word_ff.status;

endmodule

@@ rtl/i2cm_master_cmd_then_read_fsm_top.sv @@
// ----------------------------------------------------------------------------
// I2C command-then-read master sequencer, top level
// Write-command / repeated-START / read sequencer driven by bus event words.
// ----------------------------------------------------------------------------
// Usage:
//   The req_chan channel carries two kinds of word. A request word (opcode 0)
//   names the slave address, the command byte and the read length and is
//   answered with START, or with a busy rejection while a transaction runs.
//   An event word (opcode 1) reports the controller status and received byte
//   and is answered with the next bus action on rsp_chan.
//   Every accepted request word produces exactly one response word.
//   Path: an accepted word sits in the input register, is evaluated by the
//   sequencer and lands in the result register once that register is free,
//   and rsp_chan presents it from there as the response.
//   Throughput: one word per cycle while rsp_chan.ready stays high; the
//   per-word work is the phase decode, the status compare and the 8-bit
//   counter increments and compares between the two registers.
//   Stalls: when rsp_chan.ready is low, the result register holds its word
//   and the input register keeps one more, after which req_chan.ready drops.
//   Reset (synchronous, active high) empties both registers and returns the
//   sequencer to idle with all latched fields cleared.
// ----------------------------------------------------------------------------
module i2c_master_cmd_then_read_fsm_top (
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req_chan,
   i2cm_rsp_if.source rsp_chan
);
   import i2cm_pkg::*;

   pipe_ctl_type ctl;
   logic         in_vld;
   req_word_type in_word;
   rsp_word_type res;
   logic         out_free;

   // The held request word is evaluated and moved into the result register
   // whenever that register is empty or being drained this cycle.
   assign ctl.out_free = out_free;
   assign ctl.adv      = in_vld && out_free;

   i2cm_ireg u_ireg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .ctl      (ctl),
      .in_vld   (in_vld),
      .in_word  (in_word)
   );

   i2cm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .in_word (in_word),
      .res     (res)
   );

   i2cm_oreg u_oreg (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .res      (res),
      .rsp_chan (rsp_chan),
      .out_free (out_free)
   );

endmodule
